>>> src/pntt_pkg.sv
// pntt_pkg: shared types, constants and entry helpers for the two-nearest table
// no dependencies; imported by every module of the block
`default_nettype none

package pntt_pkg;

	// table geometry and field widths
	localparam int CLIENTS   = 1024;
	localparam int CLIENT_W  = $clog2(CLIENTS);
	localparam int IDX_W     = 10;
	localparam int MED_W     = 10;
	localparam int DIST_W    = 16;
	localparam int DIST_BITS = 16;
	localparam int COST_W    = 26;
	localparam int FUNC_W    = 3;
	localparam int SUM_W     = COST_W + 2;

	localparam logic [DIST_W-1:0] DIST_MASK =
		DIST_W'((64'd1 << DIST_BITS) - 64'd1);
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_OFFER   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PROBE   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_APPLY   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REBUILD = 3'd4;

	// one client entry: nearest and second-nearest slots
	typedef struct packed {
		logic [MED_W-1:0]  m1;
		logic              v1;
		logic [DIST_W-1:0] d1;
		logic [MED_W-1:0]  m2;
		logic              v2;
		logic [DIST_W-1:0] d2;
	} entry_t;

	// item held in the compute stage
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [MED_W-1:0]  medoid;
		logic [MED_W-1:0]  leaving;
		logic [DIST_W-1:0] distance;
		logic              start_probe;
	} item_t;

	// cost update request from the entry logic to the totals
	typedef struct packed {
		logic              cost_en;
		logic              probe_en;
		logic              start;
		logic [DIST_W-1:0] old1;
		logic [DIST_W-1:0] new1;
		logic [DIST_W-1:0] upd;
	} cost_op_t;

	// nearest moves to second, candidate takes nearest
	function automatic entry_t take_first(entry_t e, logic [MED_W-1:0] m,
			logic [DIST_W-1:0] d);
		entry_t r;
		r    = e;
		r.m2 = e.m1;
		r.v2 = e.v1;
		r.d2 = e.d1;
		r.m1 = m;
		r.v1 = 1'b1;
		r.d1 = d;
		return r;
	endfunction

	// candidate takes second
	function automatic entry_t take_second(entry_t e, logic [MED_W-1:0] m,
			logic [DIST_W-1:0] d);
		entry_t r;
		r    = e;
		r.m2 = m;
		r.v2 = 1'b1;
		r.d2 = d;
		return r;
	endfunction

	// top-two rule, an empty slot is infinitely far
	function automatic entry_t offer(entry_t e, logic [MED_W-1:0] m,
			logic [DIST_W-1:0] d);
		entry_t r;
		r = e;
		if (!e.v1 || d < e.d1) begin
			r = take_first(e, m, d);
		end else if (!e.v2 || d < e.d2) begin
			r = take_second(e, m, d);
		end
		return r;
	endfunction

	// clamp a signed sum into the cost range
	function automatic logic [COST_W-1:0] sat_cost(logic signed [SUM_W-1:0] x);
		logic [COST_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > $signed({2'b00, COST_MAX})) begin
			r = COST_MAX;
		end else begin
			r = x[COST_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/pntt_table.sv
// pntt_table: client entry memory, one read and one write port, read data registered
// clearing pass after reset and forwarding of the last written entry; uses pntt_pkg
`default_nettype none

module pntt_table
	import pntt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [CLIENT_W-1:0] rd_addr,
	input  wire logic                wr_en,
	input  wire logic [CLIENT_W-1:0] wr_addr,
	input  wire entry_t              wr_data,
	output entry_t                   rd_data,
	output logic                     busy
);

	entry_t              mem [CLIENTS];
	entry_t              rdata_s1;
	logic [CLIENT_W-1:0] rd_addr_s1;
	logic [CLIENT_W-1:0] clr_idx_q;
	logic                clearing_q;
	logic [CLIENT_W-1:0] byp_addr_q;
	entry_t              byp_data_q;
	logic                byp_valid_q;

	logic                mem_we;
	logic [CLIENT_W-1:0] mem_wa;
	entry_t              mem_wd;

	// clearing pass owns the write port until it is done
	assign mem_we = clearing_q || wr_en;
	assign mem_wa = clearing_q ? clr_idx_q : wr_addr;
	assign mem_wd = clearing_q ? entry_t'('0) : wr_data;

	// memory array
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_s1   <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == CLIENT_W'(CLIENTS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// last item write, covers a read issued at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (wr_en) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= wr_data;
		end
	end

	assign rd_data = (byp_valid_q && byp_addr_q == rd_addr_s1) ? byp_data_q : rdata_s1;
	assign busy    = clearing_q;

endmodule

`default_nettype wire

>>> src/pntt_update.sv
// pntt_update: new entry, recompute flag and cost request for one item
// purely combinational; uses pntt_pkg entry helpers
`default_nettype none

module pntt_update
	import pntt_pkg::*;
(
	input  wire item_t    item,
	input  wire entry_t   old,
	output entry_t        upd_entry,
	output logic          recompute,
	output cost_op_t      cost_op
);

	logic              leave1;
	logic              leave2;
	logic              alt_valid;
	logic [DIST_W-1:0] alt;

	assign leave1 = old.v1 && old.m1 == item.leaving;
	assign leave2 = old.v2 && old.m2 == item.leaving;

	// entry update per operation
	always_comb begin
		upd_entry = old;
		recompute = 1'b0;
		case (item.func)
			FN_CLEAR: begin
				upd_entry = '0;
			end
			FN_OFFER: begin
				upd_entry = offer(old, item.medoid, item.distance);
			end
			FN_APPLY: begin
				if (leave1) begin
					if (!old.v2 || item.distance <= old.d2) begin
						upd_entry.m1 = item.medoid;
						upd_entry.d1 = item.distance;
					end else begin
						upd_entry.m1 = old.m2;
						upd_entry.d1 = old.d2;
						upd_entry.m2 = '0;
						upd_entry.v2 = 1'b0;
						upd_entry.d2 = '0;
						recompute    = 1'b1;
					end
				end else if (leave2) begin
					if (!old.v1 || item.distance < old.d1) begin
						upd_entry = take_first(old, item.medoid, item.distance);
					end else begin
						upd_entry.m2 = '0;
						upd_entry.v2 = 1'b0;
						upd_entry.d2 = '0;
						recompute    = 1'b1;
					end
				end else begin
					upd_entry = offer(old, item.medoid, item.distance);
				end
			end
			FN_REBUILD: begin
				if (!(old.v1 && old.m1 == item.medoid) &&
						(!old.v2 || item.distance < old.d2)) begin
					upd_entry = take_second(old, item.medoid, item.distance);
				end
			end
			default: begin
				upd_entry = old;
			end
		endcase
	end

	// distance the client would pay after the trial swap
	assign alt_valid = leave1 ? old.v2 : old.v1;
	assign alt       = leave1 ? old.d2 : old.d1;

	always_comb begin
		cost_op.cost_en  = item.func == FN_CLEAR || item.func == FN_OFFER ||
			item.func == FN_APPLY;
		cost_op.probe_en = item.func == FN_PROBE;
		cost_op.start    = item.start_probe;
		cost_op.old1     = old.v1 ? old.d1 : '0;
		cost_op.new1     = upd_entry.v1 ? upd_entry.d1 : '0;
		cost_op.upd      = (alt_valid && alt < item.distance) ? alt : item.distance;
	end

endmodule

`default_nettype wire

>>> src/pntt_cost.sv
// pntt_cost: running total of nearest distances and swap probe estimate
// saturating updates; uses pntt_pkg
`default_nettype none

module pntt_cost
	import pntt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire cost_op_t      op,
	output logic [COST_W-1:0]  cost_next,
	output logic [COST_W-1:0]  probe_next
);

	logic [COST_W-1:0]        cost_total_q;
	logic [COST_W-1:0]        probe_total_q;
	logic [COST_W-1:0]        probe_base;
	logic signed [SUM_W-1:0]  cost_sum;
	logic signed [SUM_W-1:0]  probe_sum;

	// totals after the item in the compute stage
	assign probe_base = op.start ? cost_total_q : probe_total_q;
	assign cost_sum   = $signed({2'b00, cost_total_q}) +
		$signed(SUM_W'(op.new1)) - $signed(SUM_W'(op.old1));
	assign probe_sum  = $signed({2'b00, probe_base}) +
		$signed(SUM_W'(op.upd)) - $signed(SUM_W'(op.old1));

	assign cost_next  = (en && op.cost_en) ? sat_cost(cost_sum) : cost_total_q;
	assign probe_next = (en && op.probe_en) ? sat_cost(probe_sum) : probe_total_q;

	// total registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_total_q  <= '0;
			probe_total_q <= '0;
		end else if (en) begin
			cost_total_q  <= cost_next;
			probe_total_q <= probe_next;
		end
	end

endmodule

`default_nettype wire

>>> src/pmedian_two_nearest_table.sv
// pmedian_two_nearest_table: top level, accept stage, compute stage and result register
// instantiates pntt_table, pntt_update and pntt_cost; uses pntt_pkg
`default_nettype none

// Per-client two-nearest medoid table. Each item reads one client entry from a
// synchronous memory, updates it according to func and writes it back, while the
// total and probe costs are kept in registers. The block sustains one item per
// clock while results are taken: the entry read is issued at acceptance, the entry
// is modified and written back when its item leaves the compute stage, and the
// entry written by the item just before is forwarded when both address the same
// client. A result is loaded into the output register as its item leaves the
// compute stage and waits there until taken, which lets the next item be
// accepted meanwhile. After reset the memory is cleared one entry a cycle, and
// req_ready stays low until the clearing is done.
module pmedian_two_nearest_table
	import pntt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [IDX_W-1:0]  client,
	input  wire logic [MED_W-1:0]  medoid,
	input  wire logic [MED_W-1:0]  leaving,
	input  wire logic [DIST_W-1:0] dist_req,
	input  wire logic              start_probe,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [COST_W-1:0]      total_cost,
	output logic [COST_W-1:0]      probe_cost,
	output logic                   recompute_needed,
	output logic [MED_W-1:0]       nearest,
	output logic                   nearest_valid,
	output logic [DIST_W-1:0]      nearest_dist
);

	logic                valid_s1;
	item_t               item_s1;
	logic                in_range_s1;
	logic [CLIENT_W-1:0] addr_s1;

	logic                busy;
	logic                adv;
	logic                accept;
	logic                fire_s1;
	logic                in_range;
	entry_t              old_entry;
	entry_t              new_entry;
	entry_t              shown;
	logic                recompute;
	cost_op_t            cost_op;
	logic [COST_W-1:0]   cost_next;
	logic [COST_W-1:0]   probe_next;

	logic                rsp_valid_q;
	logic [COST_W-1:0]   total_cost_q;
	logic [COST_W-1:0]   probe_cost_q;
	logic                recompute_q;
	logic [MED_W-1:0]    nearest_q;
	logic                nearest_valid_q;
	logic [DIST_W-1:0]   nearest_dist_q;

	// handshake
	assign adv       = !valid_s1 || !rsp_valid_q || rsp_ready;
	assign req_ready = !busy && adv;
	assign accept    = req_valid && req_ready;
	assign fire_s1   = valid_s1 && adv;
	assign in_range  = 32'(client) < 32'(CLIENTS);

	// compute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	// compute stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func        <= func;
			item_s1.medoid      <= medoid;
			item_s1.leaving     <= leaving;
			item_s1.distance    <= dist_req & DIST_MASK;
			item_s1.start_probe <= start_probe;
			in_range_s1         <= in_range;
			addr_s1             <= client[CLIENT_W-1:0];
		end
	end

	pntt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (client[CLIENT_W-1:0]),
		.wr_en   (fire_s1 && in_range_s1),
		.wr_addr (addr_s1),
		.wr_data (new_entry),
		.rd_data (old_entry),
		.busy    (busy)
	);

	pntt_update u_update (
		.item      (item_s1),
		.old       (old_entry),
		.upd_entry (new_entry),
		.recompute (recompute),
		.cost_op   (cost_op)
	);

	pntt_cost u_cost (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire_s1 && in_range_s1),
		.op         (cost_op),
		.cost_next  (cost_next),
		.probe_next (probe_next)
	);

	// an out-of-range client shows an empty entry
	assign shown = in_range_s1 ? new_entry : entry_t'('0);

	// result register control, a waiting item is kept until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			total_cost_q    <= cost_next;
			probe_cost_q    <= probe_next;
			recompute_q     <= in_range_s1 && recompute;
			nearest_q       <= shown.v1 ? shown.m1 : '0;
			nearest_valid_q <= shown.v1;
			nearest_dist_q  <= shown.v1 ? shown.d1 : '0;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign total_cost       = total_cost_q;
	assign probe_cost       = probe_cost_q;
	assign recompute_needed = recompute_q;
	assign nearest          = nearest_q;
	assign nearest_valid    = nearest_valid_q;
	assign nearest_dist     = nearest_dist_q;

endmodule

`default_nettype wire

>>> src/pntt_checker.sv
// pntt_checker: port-level assertions for the two-nearest table, bound to the top level
// uses pntt_pkg widths
`default_nettype none

module pntt_checker
	import pntt_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic [FUNC_W-1:0] func,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [COST_W-1:0] total_cost,
	input wire logic              recompute_needed,
	input wire logic [MED_W-1:0]  nearest,
	input wire logic              nearest_valid,
	input wire logic [DIST_W-1:0] nearest_dist
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_cost))
		else $error("result changed while stalled");

	// an empty nearest slot reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !nearest_valid |-> nearest == '0 && nearest_dist == '0)
		else $error("empty nearest slot shows data");

	// losing the second slot never leaves the client without a nearest
	a_recompute_nearest: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && recompute_needed |-> nearest_valid)
		else $error("recompute flagged without nearest");

	// a fresh result follows an accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without accepted item");

	// recompute is only flagged by an apply item
	a_recompute_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) && recompute_needed |-> $past(func, 2) == FN_APPLY)
		else $error("recompute from an operation other than apply");

endmodule

bind pmedian_two_nearest_table pntt_checker u_pntt_checker (.*);

`default_nettype wire

>>> dv/tb_pmedian_two_nearest_table.sv
// tb_pmedian_two_nearest_table: self-checking bench for the two-nearest medoid table
// depends on pntt_pkg and pmedian_two_nearest_table; predicts every result in-bench
// directed slot cases, random swap rounds, and probe saturation under back-pressure
`default_nettype none

module tb_pmedian_two_nearest_table;
	import pntt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 300;

	// codes outside the five operations, expected to leave the entry alone
	localparam logic [FUNC_W-1:0] FN_UNUSED5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED7 = 3'd7;

	typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_PULSE} rx_mode_e;

	// one pending item plus sender controls
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  client;
		logic [MED_W-1:0]  medoid;
		logic [MED_W-1:0]  leaving;
		logic [DIST_W-1:0] distance;
		logic              start;
		logic              drain;
		logic              steady;
		logic              rx_hold;
	} req_t;

	// one result item
	typedef struct packed {
		logic [COST_W-1:0] total;
		logic [COST_W-1:0] probe;
		logic              recompute;
		logic [MED_W-1:0]  nearest;
		logic              nvalid;
		logic [DIST_W-1:0] ndist;
	} resp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	wire logic         req_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [IDX_W-1:0]  client = '0;
	logic [MED_W-1:0]  medoid = '0;
	logic [MED_W-1:0]  leaving = '0;
	logic [DIST_W-1:0] dist_req = '0;
	logic              start_probe = 1'b0;
	wire logic         rsp_valid;
	logic              rsp_ready = 1'b0;
	wire logic [COST_W-1:0] total_cost;
	wire logic [COST_W-1:0] probe_cost;
	wire logic         recompute_needed;
	wire logic [MED_W-1:0]  nearest;
	wire logic         nearest_valid;
	wire logic [DIST_W-1:0] nearest_dist;

	pmedian_two_nearest_table u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.func             (func),
		.client           (client),
		.medoid           (medoid),
		.leaving          (leaving),
		.dist_req         (dist_req),
		.start_probe      (start_probe),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.total_cost       (total_cost),
		.probe_cost       (probe_cost),
		.recompute_needed (recompute_needed),
		.nearest          (nearest),
		.nearest_valid    (nearest_valid),
		.nearest_dist     (nearest_dist)
	);

	// predicted block state
	entry_t  client_slots [CLIENTS];
	longint  cost_sum;
	longint  probe_sum;

	req_t    pend [$];
	resp_t   resp_expected [$];
	int      n_acc = 0;
	int      n_rsp = 0;
	int      n_err = 0;
	int      idle_cycles = 0;
	int      func_seen [8];
	int      n_recompute = 0;
	int      n_ceiling = 0;
	int      n_floor = 0;

	// sender and receiver pacing
	int       burst_left = 0;
	int       gap_left = 0;
	logic     hold_go = 1'b0;
	int       hold_left = 0;
	rx_mode_e rx_mode = RX_FREE;
	int       rx_left = 0;

	function automatic longint clamp_cost(longint x);
		if (x < 0) return 0;
		if (x > longint'(COST_MAX)) return longint'(COST_MAX);
		return x;
	endfunction

	// top-two insertion, an empty slot loses to any distance
	function automatic entry_t top_two(entry_t e, logic [MED_W-1:0] m, logic [DIST_W-1:0] d);
		entry_t r;
		r = e;
		if (!e.v1 || d < e.d1) begin
			r.m2 = e.m1;
			r.v2 = e.v1;
			r.d2 = e.d1;
			r.m1 = m;
			r.v1 = 1'b1;
			r.d1 = d;
		end else if (!e.v2 || d < e.d2) begin
			r.m2 = m;
			r.v2 = 1'b1;
			r.d2 = d;
		end
		return r;
	endfunction

	// advance the predicted table and totals by one item, return its result
	function automatic resp_t table_step(req_t r);
		entry_t            e;
		resp_t             o;
		logic [DIST_W-1:0] d;
		longint            old1, new1, upd, alt;
		logic              alt_ok, recomp;
		e      = client_slots[r.client];
		d      = r.distance & DIST_MASK;
		recomp = 1'b0;
		old1   = e.v1 ? longint'(e.d1) : 0;
		case (r.func)
			FN_CLEAR: e = '0;
			FN_OFFER: e = top_two(e, r.medoid, d);
			FN_PROBE: begin
				// cost after the swap: entrant or the best medoid that stays
				upd = d;
				if (e.v1 && e.m1 == r.leaving) begin
					alt_ok = e.v2;
					alt    = e.d2;
				end else begin
					alt_ok = e.v1;
					alt    = e.d1;
				end
				if (alt_ok && alt < upd) upd = alt;
				if (r.start) probe_sum = cost_sum;
				probe_sum = clamp_cost(probe_sum + upd - old1);
			end
			FN_APPLY: begin
				if (e.v1 && e.m1 == r.leaving) begin
					if (!e.v2 || d <= e.d2) begin
						e.m1 = r.medoid;
						e.d1 = d;
					end else begin
						e.m1   = e.m2;
						e.d1   = e.d2;
						e.v2   = 1'b0;
						e.m2   = '0;
						e.d2   = '0;
						recomp = 1'b1;
					end
				end else if (e.v2 && e.m2 == r.leaving) begin
					if (!e.v1 || d < e.d1) begin
						e = top_two(e, r.medoid, d);
					end else begin
						e.v2   = 1'b0;
						e.m2   = '0;
						e.d2   = '0;
						recomp = 1'b1;
					end
				end else begin
					e = top_two(e, r.medoid, d);
				end
			end
			FN_REBUILD: begin
				if (!(e.v1 && e.m1 == r.medoid) && (!e.v2 || d < e.d2)) begin
					e.m2 = r.medoid;
					e.v2 = 1'b1;
					e.d2 = d;
				end
			end
			default: ;
		endcase
		if (r.func == FN_CLEAR || r.func == FN_OFFER || r.func == FN_APPLY) begin
			new1     = e.v1 ? longint'(e.d1) : 0;
			cost_sum = clamp_cost(cost_sum + new1 - old1);
		end
		client_slots[r.client] = e;
		o.total     = cost_sum[COST_W-1:0];
		o.probe     = probe_sum[COST_W-1:0];
		o.recompute = recomp;
		o.nearest   = e.v1 ? e.m1 : '0;
		o.nvalid    = e.v1;
		o.ndist     = e.v1 ? e.d1 : '0;
		return o;
	endfunction

	function automatic req_t mk_item(logic [FUNC_W-1:0] f, int cl, int m, int lv, int d,
			bit st);
		req_t r;
		r          = '0;
		r.func     = f;
		r.client   = IDX_W'(cl);
		r.medoid   = MED_W'(m);
		r.leaving  = MED_W'(lv);
		r.distance = DIST_W'(d);
		r.start    = st;
		return r;
	endfunction

	// mostly a small pool so that leaving and candidate medoids hit table slots
	function automatic int pick_med();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
	endfunction

	function automatic int pick_client();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
	endfunction

	function automatic int pick_dist();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return 65535;
		if (sel < 7) return $urandom_range(0, 40);
		return $urandom_range(0, 65535);
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endtask

	// swap rounds (offers, probes, applies, rebuilds over a few clients) plus noise
	task automatic add_random(input int n_items);
		int                made, k, i, first, round_at;
		int                cl [8];
		int                ent, lv;
		req_t              it;
		made  = 0;
		first = pend.size();
		while (made < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				round_at = pend.size();
				ent      = pick_med();
				lv       = pick_med();
				k        = $urandom_range(2, 8);
				for (i = 0; i < k; i++) cl[i] = pick_client();
				for (i = 0; i < k; i++) begin
					repeat ($urandom_range(0, 2)) begin
						pend.push_back(mk_item(FN_OFFER, cl[i], pick_med(), 0, pick_dist(), 0));
						made++;
					end
				end
				for (i = 0; i < k; i++) begin
					pend.push_back(mk_item(FN_PROBE, cl[i], ent, lv, pick_dist(), i == 0));
					made++;
				end
				for (i = 0; i < k; i++) begin
					pend.push_back(mk_item(FN_APPLY, cl[i], ent, lv, pick_dist(), 0));
					made++;
				end
				for (i = 0; i < k; i++) begin
					repeat ($urandom_range(0, 3)) begin
						pend.push_back(mk_item(FN_REBUILD, cl[i], pick_med(), 0, pick_dist(), 0));
						made++;
					end
				end
				if ($urandom_range(0, 19) == 0) pend[round_at].drain = 1'b1;
			end else begin
				it = mk_item(FUNC_W'($urandom_range(FN_CLEAR, FN_UNUSED7)),
					$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 65535), 1'($urandom_range(0, 1)));
				pend.push_back(it);
				if (it.func <= FN_REBUILD) made++;
			end
		end
		pend[first].drain = 1'b1;
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// sender: bursts with random gaps, pauses for drain points
	always @(posedge clk or negedge arst_n) begin : sender
		req_t nx;
		logic hold_now;
		hold_now = 1'b0;
		if (!arst_n) begin
			req_valid   <= 1'b0;
			func        <= '0;
			client      <= '0;
			medoid      <= '0;
			leaving     <= '0;
			dist_req    <= '0;
			start_probe <= 1'b0;
			burst_left  <= 0;
			gap_left    <= 0;
			hold_go     <= 1'b0;
		end else begin
			if (!req_valid || req_ready) begin
				if (gap_left != 0 && !(pend.size() != 0 && pend[0].steady)) begin
					gap_left  <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pend.size() == 0 ||
						(pend[0].drain && (req_valid || n_acc != n_rsp))) begin
					req_valid <= 1'b0;
				end else begin
					nx          = pend.pop_front();
					req_valid   <= 1'b1;
					func        <= nx.func;
					client      <= nx.client;
					medoid      <= nx.medoid;
					leaving     <= nx.leaving;
					dist_req    <= nx.distance;
					start_probe <= nx.start;
					hold_now    = nx.rx_hold;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			hold_go <= hold_now;
		end
	end

	// receiver: changing stall pattern, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			rx_mode   <= RX_FREE;
			rx_left   <= 0;
		end else if (hold_go) begin
			hold_left <= RX_HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_e'($urandom_range(0, 3));
				rx_left <= $urandom_range(16, 80);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_FREE:   rsp_ready <= 1'b1;
				RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
				default:   rsp_ready <= (rx_left[2:0] != 3'd0);
			endcase
		end
	end

	// monitor: check results against predictions, predict accepted items, watchdog
	always @(posedge clk or negedge arst_n) begin : monitor
		resp_t want, got;
		req_t  seen;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got = {total_cost, probe_cost, recompute_needed, nearest, nearest_valid,
					nearest_dist};
				if (resp_expected.size() == 0) begin
					$error("result item with nothing expected: total_cost %0d", total_cost);
					n_err++;
				end else begin
					want = resp_expected.pop_front();
					check_field("total_cost", want.total, got.total);
					check_field("probe_cost", want.probe, got.probe);
					check_field("recompute_needed", want.recompute, got.recompute);
					check_field("nearest", want.nearest, got.nearest);
					check_field("nearest_valid", want.nvalid, got.nvalid);
					check_field("nearest_dist", want.ndist, got.ndist);
				end
			end
			if (req_valid && req_ready) begin
				seen = mk_item(func, client, medoid, leaving, dist_req, start_probe);
				want = table_step(seen);
				resp_expected.push_back(want);
				func_seen[seen.func]++;
				if (want.recompute) n_recompute++;
				if (want.probe == COST_MAX) n_ceiling++;
				if (seen.func == FN_PROBE && want.probe == '0) n_floor++;
			end
			n_acc <= n_acc + int'(req_valid && req_ready);
			n_rsp <= n_rsp + int'(rsp_valid && rsp_ready);
			// watchdog on handshake activity
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin : stim
		int   n_total, i;
		req_t it;
		foreach (client_slots[j]) client_slots[j] = '0;
		foreach (func_seen[j]) func_seen[j] = 0;
		cost_sum  = 0;
		probe_sum = 0;

		// client 0: fill both slots, ties against nearest and second
		pend.push_back(mk_item(FN_OFFER, 0, 5, 0, 100, 0));
		pend.push_back(mk_item(FN_OFFER, 0, 7, 0, 50, 0));
		pend.push_back(mk_item(FN_OFFER, 0, 9, 0, 50, 0));
		pend.push_back(mk_item(FN_OFFER, 0, 11, 0, 50, 0));
		// probe: nearest leaving falls back to second, then unrelated leaving
		pend.push_back(mk_item(FN_PROBE, 0, 3, 7, 80, 1));
		pend.push_back(mk_item(FN_PROBE, 0, 3, 999, 10, 0));
		// apply: nearest leaves, entrant ties second, then second promoted
		pend.push_back(mk_item(FN_APPLY, 0, 20, 7, 50, 0));
		pend.push_back(mk_item(FN_APPLY, 0, 21, 20, 60, 0));
		// rebuild: candidate equals nearest, empty second, tie, closer
		pend.push_back(mk_item(FN_REBUILD, 0, 9, 0, 1, 0));
		pend.push_back(mk_item(FN_REBUILD, 0, 30, 0, 70, 0));
		pend.push_back(mk_item(FN_REBUILD, 0, 31, 0, 70, 0));
		pend.push_back(mk_item(FN_REBUILD, 0, 32, 0, 65, 0));
		// apply: second leaves with closer entrant, then with farther entrant
		pend.push_back(mk_item(FN_APPLY, 0, 40, 32, 10, 0));
		pend.push_back(mk_item(FN_APPLY, 0, 41, 9, 60, 0));
		pend.push_back(mk_item(FN_APPLY, 0, 42, 500, 5, 0));
		pend.push_back(mk_item(FN_UNUSED5, 0, 1023, 1023, 65535, 1));
		pend.push_back(mk_item(FN_UNUSED6, 0, 0, 0, 0, 0));
		pend.push_back(mk_item(FN_UNUSED7, 0, 1023, 1023, 65535, 1));
		// client 1023: second slot filled while nearest is empty
		pend.push_back(mk_item(FN_REBUILD, 1023, 1023, 0, 65535, 0));
		pend.push_back(mk_item(FN_PROBE, 1023, 0, 1023, 65535, 1));
		pend.push_back(mk_item(FN_APPLY, 1023, 1023, 1023, 65535, 0));
		// probe estimate driven below zero
		pend.push_back(mk_item(FN_PROBE, 1023, 0, 1023, 0, 1));
		pend.push_back(mk_item(FN_PROBE, 1023, 0, 1023, 0, 0));
		pend.push_back(mk_item(FN_CLEAR, 0, 0, 0, 0, 0));
		pend.push_back(mk_item(FN_CLEAR, 1023, 1023, 1023, 65535, 1));

		add_random(70);

		// probe estimate pushed to its ceiling, starting with a long receiver hold-off
		it         = mk_item(FN_CLEAR, 1000, 0, 0, 0, 0);
		it.drain   = 1'b1;
		it.rx_hold = 1'b1;
		pend.push_back(it);
		for (i = 0; i < 1030; i++) begin
			it        = mk_item(FN_PROBE, 1000, i % 1024, 1023 - (i % 1024), 65535, i == 0);
			it.steady = 1'b1;
			pend.push_back(it);
		end

		add_random(70);
		n_total = pend.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (n_acc != n_total || n_rsp < n_total) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (resp_expected.size() != 0) begin
			$error("%0d expected result items never arrived", resp_expected.size());
			n_err++;
		end
		$display("covered %0d items: %0d clear, %0d offer, %0d probe, %0d apply, %0d rebuild, %0d unused",
			n_total, func_seen[FN_CLEAR], func_seen[FN_OFFER], func_seen[FN_PROBE],
			func_seen[FN_APPLY], func_seen[FN_REBUILD],
			func_seen[FN_UNUSED5] + func_seen[FN_UNUSED6] + func_seen[FN_UNUSED7]);
		$display("%0d second-slot rebuild flags, probe estimate at ceiling %0d and floor %0d times",
			n_recompute, n_ceiling, n_floor);
		if (n_err == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
